// ===== sv/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Holds the sequencer encodings, register map and the fixed constants
// of the integer compensation formula.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned AdcBits = 20;

  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] PressBase  = 64'd1048576;
  localparam logic [63:0] PressScale = 64'd3125;
  localparam logic [63:0] FinePerDeg = 64'd5120;
  localparam logic [63:0] PressBias  = 64'h0000_8000_0000_0000;

  // Main control states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LAUNCH = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_OUT    = 5'b10000
  } state_e;

  // Program steps of the compensation sequence
  typedef enum logic [4:0] {
    STEP_T_A = 5'd0,
    STEP_T_B = 5'd1,
    STEP_T_C = 5'd2,
    STEP_T_D = 5'd3,
    STEP_T_E = 5'd4,
    STEP_P_A = 5'd5,
    STEP_P_B = 5'd6,
    STEP_P_C = 5'd7,
    STEP_P_D = 5'd8,
    STEP_P_E = 5'd9,
    STEP_P_F = 5'd10,
    STEP_P_G = 5'd11,
    STEP_P_H = 5'd12,
    STEP_P_I = 5'd13,
    STEP_P_J = 5'd14,
    STEP_P_K = 5'd15,
    STEP_P_L = 5'd16
  } step_e;

  // Register word indexes
  typedef enum logic [2:0] {
    REG_T1   = 3'd0,
    REG_T2T3 = 3'd1,
    REG_P1   = 3'd2,
    REG_P2P3 = 3'd3,
    REG_P4P5 = 3'd4,
    REG_P6P7 = 3'd5,
    REG_P8P9 = 3'd6
  } reg_idx_e;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

endpackage

// ===== sv/pressure_temperature_compensation.sv =====
// Throughput: one beat at a time, paced by the bit-serial multiplier (one bit
// per cycle) and the radix-2 divider; the next beat is taken in the cycle after
// the result is loaded. The output register lets it enter early.
// Reset (async, active low) clears control, coefficients and fine temperature.
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: barometric sensor compensation
// Runs the 64-bit integer temperature and pressure formulas on a serial
// shift-add multiplier and a restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation #(
  parameter int unsigned RAW_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [ptc_pkg::AdcBits-1:0] raw_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic signed [9:0] temperature_deg_o,
  output logic [31:0] pressure_q24_8_o,
  output logic        zero_divisor_o
);
  import ptc_pkg::*;

  localparam int unsigned PadBits = AdcBits - RAW_BITS;

  // Control and coefficient registers
  state_e      state_q, state_d;
  step_e       step_q, step_d;
  logic [15:0] cal_t1_q, cal_p1_q;
  logic [31:0] cal_t2_t3_q, cal_p2_p3_q, cal_p4_p5_q, cal_p6_p7_q, cal_p8_p9_q;
  logic [31:0] fine_q, fine_d;
  logic        out_valid_q, out_valid_d;
  logic [6:0]  cnt_q, cnt_d;

  // Datapath registers
  logic                kind_q, kind_d;
  logic [AdcBits-1:0]  adc_q, adc_d;
  logic [63:0] v1_q, v1_d, s_q, s_d, v2_q, v2_d, t_q, t_d;
  logic [63:0] mcand_q, mcand_d, mplier_q, mplier_d, prod_q, prod_d;
  logic        msgn_q, msgn_d;
  logic [63:0] rem_q, rem_d, dnum_q, dnum_d, dden_q, dden_d;
  logic        dneg_q, dneg_d;
  logic signed [9:0] res_deg_q, res_deg_d;
  logic [31:0] res_pres_q, res_pres_d;
  logic        res_zero_q, res_zero_d;
  logic        okind_q, okind_d, ozero_q, ozero_d;
  logic signed [9:0] odeg_q, odeg_d;
  logic [31:0] opres_q, opres_d;

  // Launch requests and datapath helpers
  logic        mul_go, div_go, mul_s;
  logic [63:0] mul_a, mul_b, div_n, div_d;
  logic [6:0]  mul_n;
  logic [63:0] mul_sum, quo, a_t, b_t, pbase, f_val, v1_val, dval;
  logic [64:0] rem_sh;
  logic        cfg_wr;

  assign pready     = 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign cfg_wr     = psel & penable & pwrite;

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = okind_q;
  assign temperature_deg_o = odeg_q;
  assign pressure_q24_8_o  = opres_q;
  assign zero_divisor_o    = ozero_q;

  // Read back the register words
  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_T1:   prdata = {16'd0, cal_t1_q};
      REG_T2T3: prdata = cal_t2_t3_q;
      REG_P1:   prdata = {16'd0, cal_p1_q};
      REG_P2P3: prdata = cal_p2_p3_q;
      REG_P4P5: prdata = cal_p4_p5_q;
      REG_P6P7: prdata = cal_p6_p7_q;
      REG_P8P9: prdata = cal_p8_p9_q;
      default:  prdata = 32'd0;
    endcase
  end

  // Shared arithmetic terms
  assign mul_sum = (msgn_q && (cnt_q == 7'd1)) ? (prod_q - mcand_q) : (prod_q + mcand_q);
  assign rem_sh  = {rem_q, dnum_q[63]};
  assign quo     = dneg_q ? (64'd0 - dnum_q) : dnum_q;
  assign a_t     = 64'(adc_q >> 3) - (64'(cal_t1_q) << 1);
  assign b_t     = 64'(adc_q >> 4) - 64'(cal_t1_q);
  assign pbase   = PressBase - 64'(adc_q);
  assign f_val   = t_q + asr(prod_q, 14);
  assign v1_val  = {{32{fine_q[31]}}, fine_q} - FineOffset;
  assign dval    = asr(prod_q, 33);

  // Sequencer and serial units
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    fine_d      = fine_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    adc_d       = adc_q;
    v1_d        = v1_q;
    s_d         = s_q;
    v2_d        = v2_q;
    t_d         = t_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    prod_d      = prod_q;
    msgn_d      = msgn_q;
    rem_d       = rem_q;
    dnum_d      = dnum_q;
    dden_d      = dden_q;
    dneg_d      = dneg_q;
    res_deg_d   = res_deg_q;
    res_pres_d  = res_pres_q;
    res_zero_d  = res_zero_q;
    okind_d     = okind_q;
    odeg_d      = odeg_q;
    opres_d     = opres_q;
    ozero_d     = ozero_q;
    mul_go      = 1'b0;
    mul_a       = 64'd0;
    mul_b       = 64'd0;
    mul_n       = 7'd16;
    mul_s       = 1'b1;
    div_go      = 1'b0;
    div_n       = 64'd0;
    div_d       = 64'd1;

    // Drop the output beat once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          adc_d   = AdcBits'(raw_sample_i[RAW_BITS-1:0]) << PadBits;
          step_d  = kind_i ? STEP_P_A : STEP_T_A;
          state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        case (step_q)
          STEP_T_A: begin
            mul_go = 1'b1; mul_a = a_t; mul_b = sext16(cal_t2_t3_q[15:0]);
            step_d = STEP_T_B;
          end
          STEP_T_B: begin
            t_d    = asr(prod_q, 11);
            mul_go = 1'b1; mul_a = b_t; mul_b = b_t; mul_n = 7'd18;
            step_d = STEP_T_C;
          end
          STEP_T_C: begin
            mul_go = 1'b1; mul_a = asr(prod_q, 12); mul_b = sext16(cal_t2_t3_q[31:16]);
            step_d = STEP_T_D;
          end
          STEP_T_D: begin
            fine_d = f_val[31:0];
            div_go = 1'b1; div_n = f_val; div_d = FinePerDeg;
            step_d = STEP_T_E;
          end
          STEP_T_E: begin
            // Saturate whole degrees to the output range
            if ($signed(quo) > 64'sd511) begin
              res_deg_d = 10'sd511;
            end else if ($signed(quo) < -64'sd512) begin
              res_deg_d = -10'sd512;
            end else begin
              res_deg_d = quo[9:0];
            end
            res_pres_d = 32'd0;
            res_zero_d = 1'b0;
            state_d    = S_OUT;
          end
          STEP_P_A: begin
            v1_d   = v1_val;
            mul_go = 1'b1; mul_a = v1_val; mul_b = v1_val; mul_n = 7'd33;
            step_d = STEP_P_B;
          end
          STEP_P_B: begin
            s_d    = prod_q;
            mul_go = 1'b1; mul_a = prod_q; mul_b = sext16(cal_p6_p7_q[15:0]);
            step_d = STEP_P_C;
          end
          STEP_P_C: begin
            v2_d   = prod_q;
            mul_go = 1'b1; mul_a = v1_q; mul_b = sext16(cal_p4_p5_q[31:16]);
            step_d = STEP_P_D;
          end
          STEP_P_D: begin
            v2_d   = v2_q + (prod_q << 17) + (sext16(cal_p4_p5_q[15:0]) << 35);
            mul_go = 1'b1; mul_a = s_q; mul_b = sext16(cal_p2_p3_q[31:16]);
            step_d = STEP_P_E;
          end
          STEP_P_E: begin
            t_d    = asr(prod_q, 8);
            mul_go = 1'b1; mul_a = v1_q; mul_b = sext16(cal_p2_p3_q[15:0]);
            step_d = STEP_P_F;
          end
          STEP_P_F: begin
            mul_go = 1'b1; mul_a = PressBias + t_q + (prod_q << 12);
            mul_b  = 64'(cal_p1_q); mul_s = 1'b0;
            step_d = STEP_P_G;
          end
          STEP_P_G: begin
            v1_d = dval;
            if (dval == 64'd0) begin
              res_deg_d  = 10'sd0;
              res_pres_d = 32'd0;
              res_zero_d = 1'b1;
              state_d    = S_OUT;
            end else begin
              mul_go = 1'b1; mul_a = (pbase << 31) - v2_q;
              mul_b  = PressScale; mul_n = 7'd12; mul_s = 1'b0;
              step_d = STEP_P_H;
            end
          end
          STEP_P_H: begin
            div_go = 1'b1; div_n = prod_q; div_d = v1_q;
            step_d = STEP_P_I;
          end
          STEP_P_I: begin
            s_d    = quo;
            mul_go = 1'b1; mul_a = asr(quo, 13); mul_b = sext16(cal_p8_p9_q[31:16]);
            step_d = STEP_P_J;
          end
          STEP_P_J: begin
            mul_go = 1'b1; mul_a = prod_q; mul_b = asr(s_q, 13); mul_n = 7'd64;
            step_d = STEP_P_K;
          end
          STEP_P_K: begin
            // Hold the p9 term, start the p8 product
            t_d    = asr(prod_q, 25);
            mul_go = 1'b1; mul_a = s_q; mul_b = sext16(cal_p8_p9_q[15:0]);
            step_d = STEP_P_L;
          end
          STEP_P_L: begin
            // Final sum with the p7 offset
            res_pres_d = 32'(asr(s_q + t_q + asr(prod_q, 19), 8)
                         + (sext16(cal_p6_p7_q[31:16]) << 4));
            res_deg_d  = 10'sd0;
            res_zero_d = 1'b0;
            state_d    = S_OUT;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        if (mplier_q[0]) begin
          prod_d = mul_sum;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_LAUNCH;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, dden_q}) begin
          rem_d  = 64'(rem_sh - {1'b0, dden_q});
          dnum_d = {dnum_q[62:0], 1'b1};
        end else begin
          rem_d  = rem_sh[63:0];
          dnum_d = {dnum_q[62:0], 1'b0};
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_LAUNCH;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          okind_d     = kind_q;
          odeg_d      = res_deg_q;
          opres_d     = res_pres_q;
          ozero_d     = res_zero_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Start the serial multiplier
    if (mul_go) begin
      mcand_d  = mul_a;
      mplier_d = mul_b;
      cnt_d    = mul_n;
      prod_d   = 64'd0;
      state_d  = S_MUL;
      msgn_d   = mul_s;
    end

    // Start the divider on magnitudes
    if (div_go) begin
      dneg_d  = div_n[63] ^ div_d[63];
      dnum_d  = div_n[63] ? (64'd0 - div_n) : div_n;
      dden_d  = div_d[63] ? (64'd0 - div_d) : div_d;
      rem_d   = 64'd0;
      cnt_d   = 7'd64;
      state_d = S_DIV;
    end
  end

  // Control and coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_T_A;
      fine_q      <= 32'd0;
      out_valid_q <= 1'b0;
      cnt_q       <= 7'd0;
      cal_t1_q    <= 16'd0;
      cal_t2_t3_q <= 32'd0;
      cal_p1_q    <= 16'd0;
      cal_p2_p3_q <= 32'd0;
      cal_p4_p5_q <= 32'd0;
      cal_p6_p7_q <= 32'd0;
      cal_p8_p9_q <= 32'd0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      fine_q      <= fine_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_wr) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_T1:   cal_t1_q    <= pwdata[15:0];
          REG_T2T3: cal_t2_t3_q <= pwdata;
          REG_P1:   cal_p1_q    <= pwdata[15:0];
          REG_P2P3: cal_p2_p3_q <= pwdata;
          REG_P4P5: cal_p4_p5_q <= pwdata;
          REG_P6P7: cal_p6_p7_q <= pwdata;
          REG_P8P9: cal_p8_p9_q <= pwdata;
          default:  ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    adc_q      <= adc_d;
    v1_q       <= v1_d;
    s_q        <= s_d;
    v2_q       <= v2_d;
    t_q        <= t_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    prod_q     <= prod_d;
    msgn_q     <= msgn_d;
    rem_q      <= rem_d;
    dnum_q     <= dnum_d;
    dden_q     <= dden_d;
    dneg_q     <= dneg_d;
    res_deg_q  <= res_deg_d;
    res_pres_q <= res_pres_d;
    res_zero_q <= res_zero_d;
    okind_q    <= okind_d;
    odeg_q     <= odeg_d;
    opres_q    <= opres_d;
    ozero_q    <= ozero_d;
  end

`ifndef ASSERT_OFF
  a_zero_is_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divisor_o |-> result_kind_o && pressure_q24_8_o == 32'd0)
    else $error("zero divisor flag on a non-pressure or nonzero result");
  a_temp_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> pressure_q24_8_o == 32'd0 && !zero_divisor_o)
    else $error("temperature result carries pressure fields");
  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_DIV) |-> cnt_q != 7'd0)
    else $error("serial unit running with an empty count");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_LAUNCH)
    else $error("accepted beat did not start the sequence");
`endif

endmodule
